/* src/asdpg_pkg.sv */
package asdpg_pkg;

    // field widths fixed by the item and register formats
    localparam int MIN_SPEED_W = 10;
    localparam int BRAKE_W     = 7;
    localparam int TENTHS_W    = 4;
    localparam int PULSE_W     = 8;
    localparam int WHEEL_W     = 3;
    localparam int NUM_WHEELS  = 4;

    // slipping wheel code when no wheel slips
    localparam logic [WHEEL_W-1:0] NO_SLIP = 3'd4;

    // register reset values
    localparam logic [MIN_SPEED_W-1:0] MIN_SPEED_RST   = 10'd10;
    localparam logic [BRAKE_W-1:0]     MIN_BRAKE_RST   = 7'd5;
    localparam logic [TENTHS_W-1:0]    SLIP_TENTHS_RST = 4'd9;
    localparam logic [PULSE_W-1:0]     ON_PULSES_RST   = 8'd25;
    localparam logic [PULSE_W-1:0]     OFF_PULSES_RST  = 8'd25;

    // apb register map, word index
    localparam int PADDR_W = 5;
    typedef enum logic [2:0] {
        REG_MIN_SPEED   = 3'd0,
        REG_MIN_BRAKE   = 3'd1,
        REG_SLIP_TENTHS = 3'd2,
        REG_ON_PULSES   = 3'd3,
        REG_OFF_PULSES  = 3'd4
    } reg_idx_t;

    // request kinds
    typedef enum logic [1:0] {
        REQ_SAMPLE = 2'd0,
        REQ_TICK   = 2'd1,
        REQ_CMD    = 2'd2
    } req_kind_t;

    typedef struct packed {
        logic [MIN_SPEED_W-1:0] min_speed;
        logic [BRAKE_W-1:0]     min_brake;
        logic [TENTHS_W-1:0]    slip_tenths;
        logic [PULSE_W-1:0]     on_pulses;
        logic [PULSE_W-1:0]     off_pulses;
    } cfg_t;

    typedef struct packed {
        logic               above;
        logic               found;
        logic [WHEEL_W-1:0] wheel;
    } slip_t;

endpackage

/* src/asdpg_if.sv */
// request channel: samples, ticks and commands
interface asdpg_req_if #(parameter int SPEED_BITS = 10);
    logic                  valid;
    logic                  ready;
    logic [1:0]            req_type;
    logic [SPEED_BITS-1:0] wheel_speed_fl;
    logic [SPEED_BITS-1:0] wheel_speed_fr;
    logic [SPEED_BITS-1:0] wheel_speed_rl;
    logic [SPEED_BITS-1:0] wheel_speed_rr;
    logic [SPEED_BITS-1:0] expected_fl;
    logic [SPEED_BITS-1:0] expected_fr;
    logic [SPEED_BITS-1:0] expected_rl;
    logic [SPEED_BITS-1:0] expected_rr;
    logic [6:0]            brake_level;
    logic                  abs_request;

    modport source (
        output valid, req_type, wheel_speed_fl, wheel_speed_fr, wheel_speed_rl,
               wheel_speed_rr, expected_fl, expected_fr, expected_rl, expected_rr,
               brake_level, abs_request,
        input  ready
    );
    modport sink (
        input  valid, req_type, wheel_speed_fl, wheel_speed_fr, wheel_speed_rl,
               wheel_speed_rr, expected_fl, expected_fr, expected_rl, expected_rr,
               brake_level, abs_request,
        output ready
    );
endinterface

// status channel: one transaction per request
interface asdpg_rsp_if;
    logic       valid;
    logic       ready;
    logic       abs_on;
    logic       brake_drive_enabled;
    logic [2:0] slip_wheel;
    logic       above_speed;

    modport source (
        output valid, abs_on, brake_drive_enabled, slip_wheel, above_speed,
        input  ready
    );
    modport sink (
        input  valid, abs_on, brake_drive_enabled, slip_wheel, above_speed,
        output ready
    );
endinterface

/* src/asdpg_cfg_regs.sv */
module asdpg_cfg_regs
    import asdpg_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    output cfg_t               cfg
);

    cfg_t     cfg_reg;
    logic     wr_en;
    reg_idx_t idx;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign idx    = reg_idx_t'(paddr[PADDR_W-1:2]);
    assign cfg    = cfg_reg;

    // register writes, out-of-range addresses ignored
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.min_speed   <= MIN_SPEED_RST;
            cfg_reg.min_brake   <= MIN_BRAKE_RST;
            cfg_reg.slip_tenths <= SLIP_TENTHS_RST;
            cfg_reg.on_pulses   <= ON_PULSES_RST;
            cfg_reg.off_pulses  <= OFF_PULSES_RST;
        end
        else if (wr_en)
        begin
            unique case (idx)
                REG_MIN_SPEED:   cfg_reg.min_speed   <= pwdata[MIN_SPEED_W-1:0];
                REG_MIN_BRAKE:   cfg_reg.min_brake   <= pwdata[BRAKE_W-1:0];
                REG_SLIP_TENTHS: cfg_reg.slip_tenths <= pwdata[TENTHS_W-1:0];
                REG_ON_PULSES:   cfg_reg.on_pulses   <= pwdata[PULSE_W-1:0];
                REG_OFF_PULSES:  cfg_reg.off_pulses  <= pwdata[PULSE_W-1:0];
                default:         ;
            endcase
        end
    end

    // read mux
    always_comb
    begin
        unique case (idx)
            REG_MIN_SPEED:   prdata = 32'(cfg_reg.min_speed);
            REG_MIN_BRAKE:   prdata = 32'(cfg_reg.min_brake);
            REG_SLIP_TENTHS: prdata = 32'(cfg_reg.slip_tenths);
            REG_ON_PULSES:   prdata = 32'(cfg_reg.on_pulses);
            REG_OFF_PULSES:  prdata = 32'(cfg_reg.off_pulses);
            default:         prdata = 32'd0;
        endcase
    end

endmodule

/* src/asdpg_slip_detect.sv */
module asdpg_slip_detect
    import asdpg_pkg::*;
#(
    parameter int SPEED_BITS = 10
)
(
    input  logic [SPEED_BITS-1:0] speed [NUM_WHEELS],
    input  logic [SPEED_BITS-1:0] expected [NUM_WHEELS],
    input  logic [BRAKE_W-1:0]    brake,
    input  cfg_t                  cfg,
    output slip_t                 slip
);

    localparam int PW = SPEED_BITS + 4;
    localparam int MW = (SPEED_BITS > MIN_SPEED_W) ? SPEED_BITS : MIN_SPEED_W;
    localparam logic [MW-1:0] SMASK = MW'((32'd1 << SPEED_BITS) - 32'd1);

    logic [SPEED_BITS-1:0] max_a;
    logic [SPEED_BITS-1:0] max_b;
    logic [SPEED_BITS-1:0] max_all;
    logic [MW-1:0]         min_ext;
    logic                  above;
    logic                  armed;
    logic [PW-1:0]         spd_inc [NUM_WHEELS];
    logic [PW-1:0]         lhs [NUM_WHEELS];
    logic [PW-1:0]         thresh [NUM_WHEELS];
    logic [NUM_WHEELS-1:0] below;

    // largest wheel speed, two-level compare tree
    assign max_a   = (speed[1] > speed[0]) ? speed[1] : speed[0];
    assign max_b   = (speed[3] > speed[2]) ? speed[3] : speed[2];
    assign max_all = (max_b > max_a) ? max_b : max_a;

    // min_speed taken modulo the speed width
    assign min_ext = MW'(cfg.min_speed) & SMASK;
    assign above   = (MW'(max_all) >= min_ext);
    assign armed   = above && (brake >= cfg.min_brake);

    // spd < floor(exp*t/10) is the same as 10*(spd+1) <= exp*t
    always_comb
    begin
        for (int i = 0; i < NUM_WHEELS; i++)
        begin
            spd_inc[i] = PW'(speed[i]) + PW'(1);
            lhs[i]     = (spd_inc[i] << 3) + (spd_inc[i] << 1);
            thresh[i]  = PW'(expected[i]) * PW'(cfg.slip_tenths);
            below[i]   = (lhs[i] <= thresh[i]);
        end
    end

    // first slipping wheel wins
    always_comb
    begin
        slip.above = above;
        slip.found = armed && (below != '0);
        if (!armed)
            slip.wheel = NO_SLIP;
        else if (below[0])
            slip.wheel = 3'd0;
        else if (below[1])
            slip.wheel = 3'd1;
        else if (below[2])
            slip.wheel = 3'd2;
        else if (below[3])
            slip.wheel = 3'd3;
        else
            slip.wheel = NO_SLIP;
    end

endmodule

/* src/abs_slip_detect_pulse_gate_core.sv */
// anti-lock braking supervisor: wheel slip detection and brake pulse gating
//
// req channel (valid/ready) carries three kinds of transaction: a speed sample
// (four wheel speeds, four expected speeds, brake level), a pwm period tick,
// or an abs on/off command. rsp channel returns one transaction for every
// request with the state after it: abs_on, brake_drive_enabled, slip_wheel
// (4 = none) and above_speed.
// the apb port sets min_speed, min_brake, slip_tenths, on_pulses and
// off_pulses at byte addresses 0, 4, 8, 12, 16; write it only while idle.
// an accepted request loads the input register; its result loads the result
// register once that has room. throughput: one request per cycle while rsp
// does not stall, the state update being combinational between the two
// registers.
// when rsp stalls the result register holds, the input register fills,
// and req.ready drops; nothing is lost.
// reset clears the state: abs off, drive enabled, no slip, speed flag low,
// and loads the register defaults; no clearing pass is needed.
module abs_slip_detect_pulse_gate_core
    import asdpg_pkg::*;
#(
    parameter int SPEED_BITS = 10
)
(
    input  logic               clk,
    input  logic               rst_n,
    asdpg_req_if.sink          req,
    asdpg_rsp_if.source        rsp,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    cfg_t  cfg;
    slip_t slip;

    // input register
    logic                  s1_valid_reg;
    logic [1:0]            s1_type_reg;
    logic [SPEED_BITS-1:0] s1_speed_reg [NUM_WHEELS];
    logic [SPEED_BITS-1:0] s1_exp_reg [NUM_WHEELS];
    logic [BRAKE_W-1:0]    s1_brake_reg;
    logic                  s1_abs_req_reg;

    // supervisor state
    logic               abs_active_reg, abs_active_next;
    logic               in_pause_reg, in_pause_next;
    logic [PULSE_W-1:0] period_count_reg, period_count_next;
    logic               drive_en_reg, drive_en_next;
    logic [WHEEL_W-1:0] slip_idx_reg, slip_idx_next;
    logic               speed_flag_reg, speed_flag_next;

    // result register
    logic out_valid_reg;

    logic               out_room;
    logic               advance;
    logic [PULSE_W-1:0] count_inc;
    logic [PULSE_W-1:0] limit;

    asdpg_cfg_regs u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    asdpg_slip_detect #(
        .SPEED_BITS (SPEED_BITS)
    ) u_slip (
        .speed    (s1_speed_reg),
        .expected (s1_exp_reg),
        .brake    (s1_brake_reg),
        .cfg      (cfg),
        .slip     (slip)
    );

    // handshake: stage moves when result register is free or being drained
    assign out_room  = !out_valid_reg || rsp.ready;
    assign advance   = s1_valid_reg && out_room;
    assign req.ready = !s1_valid_reg || out_room;

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (req.ready)
            s1_valid_reg <= req.valid;
    end

    always_ff @(posedge clk)
    begin
        if (req.valid && req.ready)
        begin
            s1_type_reg     <= req.req_type;
            s1_speed_reg[0] <= req.wheel_speed_fl;
            s1_speed_reg[1] <= req.wheel_speed_fr;
            s1_speed_reg[2] <= req.wheel_speed_rl;
            s1_speed_reg[3] <= req.wheel_speed_rr;
            s1_exp_reg[0]   <= req.expected_fl;
            s1_exp_reg[1]   <= req.expected_fr;
            s1_exp_reg[2]   <= req.expected_rl;
            s1_exp_reg[3]   <= req.expected_rr;
            s1_brake_reg    <= req.brake_level;
            s1_abs_req_reg  <= req.abs_request;
        end
    end

    // pulse gate counter
    assign count_inc = period_count_reg + PULSE_W'(1);
    assign limit     = in_pause_reg ? cfg.off_pulses : cfg.on_pulses;

    // next state per request kind
    always_comb
    begin
        abs_active_next   = abs_active_reg;
        in_pause_next     = in_pause_reg;
        period_count_next = period_count_reg;
        drive_en_next     = drive_en_reg;
        slip_idx_next     = slip_idx_reg;
        speed_flag_next   = speed_flag_reg;
        case (req_kind_t'(s1_type_reg))
            REQ_SAMPLE:
            begin
                speed_flag_next = slip.above;
                slip_idx_next   = slip.wheel;
                if (slip.found)
                    abs_active_next = 1'b1;
            end
            REQ_TICK:
            begin
                if (abs_active_reg)
                begin
                    if (count_inc == limit)
                    begin
                        period_count_next = '0;
                        in_pause_next     = !in_pause_reg;
                        drive_en_next     = in_pause_reg;
                    end
                    else
                    begin
                        period_count_next = count_inc;
                    end
                end
            end
            REQ_CMD:
            begin
                if (!abs_active_reg && s1_abs_req_reg)
                begin
                    abs_active_next = 1'b1;
                end
                else if (abs_active_reg && !s1_abs_req_reg)
                begin
                    abs_active_next   = 1'b0;
                    period_count_next = '0;
                    drive_en_next     = 1'b1;
                end
            end
            default:
            begin
            end
        endcase
    end

    // state update, once per transaction
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            abs_active_reg   <= 1'b0;
            in_pause_reg     <= 1'b0;
            period_count_reg <= '0;
            drive_en_reg     <= 1'b1;
            slip_idx_reg     <= NO_SLIP;
            speed_flag_reg   <= 1'b0;
        end
        else if (advance)
        begin
            abs_active_reg   <= abs_active_next;
            in_pause_reg     <= in_pause_next;
            period_count_reg <= period_count_next;
            drive_en_reg     <= drive_en_next;
            slip_idx_reg     <= slip_idx_next;
            speed_flag_reg   <= speed_flag_next;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_room)
            out_valid_reg <= s1_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            rsp.abs_on              <= abs_active_next;
            rsp.brake_drive_enabled <= drive_en_next;
            rsp.slip_wheel          <= slip_idx_next;
            rsp.above_speed         <= speed_flag_next;
        end
    end

    assign rsp.valid = out_valid_reg;

endmodule

/* src/asdpg_checker.sv */
module asdpg_checker
    import asdpg_pkg::*;
(
    input logic               clk,
    input logic               rst_n,
    input logic               rsp_valid,
    input logic               rsp_ready,
    input logic               abs_on,
    input logic               brake_drive_enabled,
    input logic [WHEEL_W-1:0] slip_wheel,
    input logic               above_speed
);

    // a stalled status transaction stays offered
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid)
        else $error("status transaction dropped while stalled");

    // brake output is only ever gated while abs is on
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !abs_on |-> brake_drive_enabled)
        else $error("brake drive disabled with abs off");

    // a reported slip comes from a sample that also set the speed flag
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (slip_wheel != NO_SLIP) |-> above_speed)
        else $error("slip reported without speed flag");

    // consecutive results: abs can only drop together with the drive enable restored
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_ready ##1 rsp_valid && $fell(abs_on) |-> brake_drive_enabled)
        else $error("abs switched off without re-enabling the brake drive");

endmodule

bind abs_slip_detect_pulse_gate_core asdpg_checker u_asdpg_checker (
    .clk                 (clk),
    .rst_n               (rst_n),
    .rsp_valid           (rsp.valid),
    .rsp_ready           (rsp.ready),
    .abs_on              (rsp.abs_on),
    .brake_drive_enabled (rsp.brake_drive_enabled),
    .slip_wheel          (rsp.slip_wheel),
    .above_speed         (rsp.above_speed)
);
